FILE: rtl/albf_pkg.sv
// ----------------------------------------------------------------------------
// albf_pkg
// Shared types, operation codes and constant tables of the angular basis fit.
// ----------------------------------------------------------------------------
package albf_pkg;

  typedef enum logic [4:0] {
    OP_NOP, OP_SQ, OP_C, OP_B, OP_A, OP_SIN, OP_BASIS, OP_QUAD, OP_ACC,
    OP_LOAD, OP_SHIFT, OP_COF, OP_WSTART, OP_WWAIT, OP_DET, OP_SING,
    OP_DSTART, OP_DWAIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic last;
    logic fits;
    logic mul_done;
    logic div_done;
    logic det_zero;
  } stat_t;

  localparam logic signed [32:0] SIN_A = 33'sd1686629713;
  localparam logic signed [32:0] SIN_B = 33'sd688904866;
  localparam logic signed [32:0] SIN_C = 33'sd76016977;

  // Product pairs of the accumulation step; operand code 3 is the sample value.
  localparam logic [1:0] ACC_A [16] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd0, 2'd1,
                                        2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};
  localparam logic [1:0] ACC_B [16] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3,
                                        2'd3, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0};

  // Cofactor products over the six unique matrix entries.
  localparam logic [2:0] COF_A [16] = '{3'd3, 3'd4, 3'd2, 3'd1, 3'd1, 3'd2, 3'd0, 3'd2,
                                        3'd2, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] COF_B [16] = '{3'd5, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3, 3'd5, 3'd2,
                                        3'd1, 3'd4, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0, 3'd0};

  // Wide products: W_X codes 0 to 2 pick a matrix entry, 3 to 5 a right-hand sum.
  localparam logic [2:0] W_X [16] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4,
                                      3'd5, 3'd3, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0};
  localparam logic [2:0] W_Y [16] = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd1, 3'd3,
                                      3'd4, 3'd2, 3'd4, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0};

endpackage

FILE: rtl/albf_smul.sv
// ----------------------------------------------------------------------------
// albf_smul
// Signed 64 by 64 bit shift-and-add multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module albf_smul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  output logic                 done,
  output logic signed [127:0]  p
);

  logic         busy_r, fin_r, done_r, neg_r;
  logic [5:0]   cnt_r;
  logic [127:0] mc_r, acc_r;
  logic [63:0]  mp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
      neg_r  <= a[63] ^ b[63];
      mc_r   <= {64'd0, (a[63] ? 64'(-a) : 64'(a))};
      mp_r   <= b[63] ? 64'(-b) : 64'(b);
      acc_r  <= 128'd0;
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_r <= acc_r + mc_r;
      end
      mc_r  <= mc_r << 1;
      mp_r  <= mp_r >> 1;
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      acc_r  <= neg_r ? -acc_r : acc_r;
      fin_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

FILE: rtl/albf_div.sv
// ----------------------------------------------------------------------------
// albf_div
// Signed 128 bit restoring divider with a saturated 32 bit quotient.
// ----------------------------------------------------------------------------
module albf_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [127:0]  num,
  input  logic signed [127:0]  den,
  output logic                 done,
  output logic [31:0]          q
);

  logic         busy_r, fin_r, done_r, neg_r;
  logic [6:0]   cnt_r;
  logic [127:0] n_r, d_r, quo_r;
  logic [128:0] rem_r, rem2;
  logic [31:0]  q_r;

  assign rem2 = {rem_r[127:0], n_r[127]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
      neg_r  <= num[127] ^ den[127];
      n_r    <= num[127] ? 128'(-num) : 128'(num);
      d_r    <= den[127] ? 128'(-den) : 128'(den);
      rem_r  <= 129'd0;
      quo_r  <= 128'd0;
    end else if (busy_r) begin
      if (rem2 >= {1'b0, d_r}) begin
        rem_r <= rem2 - {1'b0, d_r};
        quo_r <= {quo_r[126:0], 1'b1};
      end else begin
        rem_r <= rem2;
        quo_r <= {quo_r[126:0], 1'b0};
      end
      n_r   <= n_r << 1;
      cnt_r <= cnt_r + 7'd1;
      if (cnt_r == 7'd127) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      if (neg_r) begin
        q_r <= (quo_r > 128'h8000_0000) ? 32'h8000_0000 : 32'(-quo_r[31:0]);
      end else begin
        q_r <= (quo_r > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_r[31:0];
      end
      fin_r  <= 1'b0;
      done_r <= 1'b1;
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

FILE: rtl/albf_dpath.sv
// ----------------------------------------------------------------------------
// albf_dpath
// Datapath: sine evaluation, basis terms, accumulators and the 3x3 solve.
// ----------------------------------------------------------------------------
module albf_dpath #(
  parameter int ANGLE_BITS  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [ANGLE_BITS-1:0]         angle,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last,
  input  logic                          cfg_we,
  input  logic                          cfg_mode,
  input  albf_pkg::cmd_t                cmd,
  output albf_pkg::stat_t               stat,
  output logic [31:0]                   coef_first,
  output logic [31:0]                   coef_second,
  output logic [31:0]                   coef_third,
  output logic                          singular
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic                          mode_r, last_r, en_r, sing_r;
  logic [1:0]                    q_r;
  logic [13:0]                   t_r;
  logic signed [SAMPLE_BITS-1:0] v_r;
  logic [14:0]                   z2_r;
  logic signed [65:0]            prod_r, pshift;
  logic [15:0]                   smag_r, cmag_r;
  logic signed [16:0]            c_r, s_r, c_nxt, s_nxt;
  logic signed [16:0]            b_r [3];
  logic [47:0]                   sum_r [9];
  logic [CW-1:0]                 cnt_r;
  logic signed [47:0]            m_r [6];
  logic signed [47:0]            r_r [3];
  logic signed [63:0]            hold_r;
  logic signed [63:0]            cof_r [6];
  logic signed [127:0]           acc_r, det_r;
  logic [31:0]                   coef_r [3];
  logic [ANGLE_BITS+15:0]        aext;
  logic [15:0]                   ph;
  logic [14:0]                   x_s;
  logic signed [32:0]            ma, mb;
  logic signed [32:0]            opnd [4];
  logic                          fits;
  logic                          mul_start, mul_done, div_start, div_done;
  logic signed [63:0]            wx, wy;
  logic signed [127:0]           wp;
  logic [31:0]                   dq;
  logic [2:0]                    wxs;
  logic [3:0]                    k;

  assign k    = cmd.idx;
  assign aext = {angle, 16'd0};
  assign ph   = aext[ANGLE_BITS+15 -: 16];
  assign x_s  = k[0] ? (15'd16384 - {1'b0, t_r}) : {1'b0, t_r};
  assign pshift = prod_r >>> 14;

  always_comb begin
    unique case (q_r)
      2'd0: begin c_nxt = 17'(cmag_r);  s_nxt = 17'(smag_r);  end
      2'd1: begin c_nxt = -17'(smag_r); s_nxt = 17'(cmag_r);  end
      2'd2: begin c_nxt = -17'(cmag_r); s_nxt = -17'(smag_r); end
      default: begin c_nxt = 17'(smag_r); s_nxt = -17'(cmag_r); end
    endcase
  end

  always_comb begin
    fits = 1'b1;
    for (int i = 0; i < 6; i++) begin
      if (m_r[i] > 48'sd1073741824 || m_r[i] < -48'sd1073741824) fits = 1'b0;
    end
  end

  always_comb begin
    opnd[0] = {{16{b_r[0][16]}}, b_r[0]};
    opnd[1] = {{16{b_r[1][16]}}, b_r[1]};
    opnd[2] = {{16{b_r[2][16]}}, b_r[2]};
    opnd[3] = {{(33-SAMPLE_BITS){v_r[SAMPLE_BITS-1]}}, v_r};
  end

  always_comb begin
    ma = 33'sd0;
    mb = 33'sd0;
    case (cmd.op)
      albf_pkg::OP_SQ: begin ma = 33'(x_s); mb = 33'(x_s); end
      albf_pkg::OP_C:  begin ma = albf_pkg::SIN_C; mb = pshift[32:0]; end
      albf_pkg::OP_B:  begin ma = albf_pkg::SIN_B - pshift[32:0]; mb = 33'(z2_r); end
      albf_pkg::OP_A:  begin ma = albf_pkg::SIN_A - pshift[32:0]; mb = 33'(x_s); end
      albf_pkg::OP_QUAD: begin
        ma = (k == 4'd1) ? 33'(s_r) : 33'(c_r);
        mb = (k == 4'd0) ? 33'(c_r) : 33'(s_r);
      end
      albf_pkg::OP_ACC: begin
        ma = opnd[albf_pkg::ACC_A[k]];
        mb = opnd[albf_pkg::ACC_B[k]];
      end
      albf_pkg::OP_COF: begin
        ma = m_r[albf_pkg::COF_A[k]][32:0];
        mb = m_r[albf_pkg::COF_B[k]][32:0];
      end
      default: begin ma = 33'sd0; mb = 33'sd0; end
    endcase
  end

  assign wxs       = albf_pkg::W_X[k];
  assign wx        = (wxs < 3'd3) ? 64'(m_r[wxs]) : 64'(r_r[2'(wxs - 3'd3)]);
  assign wy        = cof_r[albf_pkg::W_Y[k]];
  assign mul_start = (cmd.op == albf_pkg::OP_WSTART);
  assign div_start = (cmd.op == albf_pkg::OP_DSTART);

  albf_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (wx),
    .b     (wy),
    .done  (mul_done),
    .p     (wp)
  );

  albf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r <<< 16),
    .den   (det_r),
    .done  (div_done),
    .q     (dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      cnt_r  <= '0;
      for (int i = 0; i < 9; i++) sum_r[i] <= 48'd0;
    end else begin
      if (cfg_we) mode_r <= cfg_mode;
      if (load) begin
        q_r    <= ph[15:14];
        t_r    <= ph[13:0];
        v_r    <= sample_value;
        last_r <= last;
        en_r   <= (cnt_r < CW'(MAX_SAMPLES));
      end
      prod_r <= ma * mb;
      case (cmd.op)
        albf_pkg::OP_C: z2_r <= pshift[14:0];
        albf_pkg::OP_SIN: begin
          if (k[0]) cmag_r <= 16'((prod_r + 66'sd268435456) >>> 29);
          else      smag_r <= 16'((prod_r + 66'sd268435456) >>> 29);
        end
        albf_pkg::OP_BASIS: begin
          c_r <= c_nxt;
          s_r <= s_nxt;
          if (mode_r) begin
            b_r[0] <= c_nxt;
            b_r[1] <= s_nxt;
            b_r[2] <= 17'sd32768;
          end
        end
        albf_pkg::OP_QUAD: begin
          if (k == 4'd1) b_r[0] <= 17'((prod_r + 66'sd16384) >>> 15);
          if (k == 4'd2) b_r[1] <= 17'((prod_r + 66'sd16384) >>> 15);
          if (k == 4'd3) b_r[2] <= 17'((prod_r + 66'sd8192) >>> 14);
        end
        albf_pkg::OP_ACC: begin
          if (en_r && k != 4'd0) sum_r[k - 4'd1] <= sum_r[k - 4'd1] + prod_r[47:0];
          if (en_r && k == 4'd9) cnt_r <= cnt_r + CW'(1);
        end
        albf_pkg::OP_LOAD: begin
          for (int i = 0; i < 6; i++) m_r[i] <= sum_r[i];
          for (int i = 0; i < 3; i++) r_r[i] <= sum_r[i+6];
          for (int i = 0; i < 9; i++) sum_r[i] <= 48'd0;
          cnt_r <= '0;
        end
        albf_pkg::OP_SHIFT: begin
          if (!fits) begin
            for (int i = 0; i < 6; i++) m_r[i] <= m_r[i] >>> 1;
            for (int i = 0; i < 3; i++) r_r[i] <= r_r[i] >>> 1;
          end
        end
        albf_pkg::OP_COF: begin
          if (k[0]) hold_r <= prod_r[63:0];
          else if (k != 4'd0) cof_r[k[3:1] - 3'd1] <= hold_r - prod_r[63:0];
        end
        albf_pkg::OP_WWAIT: begin
          if (mul_done) begin
            case (k) inside
              4'd0, 4'd3, 4'd6, 4'd9: acc_r <= wp;
              default:                acc_r <= acc_r + wp;
            endcase
          end
        end
        albf_pkg::OP_DET: begin
          det_r  <= acc_r;
          sing_r <= 1'b0;
        end
        albf_pkg::OP_SING: begin
          sing_r <= 1'b1;
          for (int i = 0; i < 3; i++) coef_r[i] <= 32'd0;
        end
        albf_pkg::OP_DWAIT: begin
          if (div_done) coef_r[k[1:0]] <= dq;
        end
        default: ;
      endcase
    end
  end

  assign stat.mode     = mode_r;
  assign stat.last     = last_r;
  assign stat.fits     = fits;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;
  assign stat.det_zero = (acc_r == 128'sd0);

  assign coef_first  = coef_r[0];
  assign coef_second = coef_r[1];
  assign coef_third  = coef_r[2];
  assign singular    = sing_r;

endmodule

FILE: rtl/albf_ctrl.sv
// ----------------------------------------------------------------------------
// albf_ctrl
// Controller: sequences the datapath through sample intake and the solve.
// ----------------------------------------------------------------------------
module albf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_accept,
  input  logic            out_tready,
  input  albf_pkg::stat_t stat,
  output albf_pkg::cmd_t  cmd,
  output logic            in_tready,
  output logic            out_tvalid
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_C, ST_B, ST_A, ST_SIN, ST_BASIS, ST_QUAD, ST_ACC,
    ST_LOAD, ST_SHIFT, ST_COF, ST_WSTART, ST_WWAIT, ST_DET, ST_SING,
    ST_DSTART, ST_DWAIT, ST_OUT
  } state_t;

  state_t     state_r;
  logic [3:0] idx_r;
  logic [1:0] di_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= 4'd0;
      di_r    <= 2'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_accept) begin
          state_r <= ST_SQ;
          idx_r   <= 4'd0;
        end
        ST_SQ: state_r <= ST_C;
        ST_C:  state_r <= ST_B;
        ST_B:  state_r <= ST_A;
        ST_A:  state_r <= ST_SIN;
        ST_SIN: begin
          if (idx_r == 4'd0) begin
            idx_r   <= 4'd1;
            state_r <= ST_SQ;
          end else begin
            state_r <= ST_BASIS;
          end
        end
        ST_BASIS: begin
          idx_r   <= 4'd0;
          state_r <= stat.mode ? ST_ACC : ST_QUAD;
        end
        ST_QUAD: begin
          if (idx_r == 4'd3) begin
            idx_r   <= 4'd0;
            state_r <= ST_ACC;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        ST_ACC: begin
          if (idx_r == 4'd9) begin
            state_r <= stat.last ? ST_LOAD : ST_IDLE;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        ST_LOAD: state_r <= ST_SHIFT;
        ST_SHIFT: if (stat.fits) begin
          idx_r   <= 4'd0;
          state_r <= ST_COF;
        end
        ST_COF: begin
          if (idx_r == 4'd12) begin
            idx_r   <= 4'd0;
            state_r <= ST_WSTART;
          end else begin
            idx_r <= idx_r + 4'd1;
          end
        end
        ST_WSTART: state_r <= ST_WWAIT;
        ST_WWAIT: if (stat.mul_done) begin
          if (idx_r == 4'd2) begin
            state_r <= ST_DET;
          end else if (idx_r == 4'd5 || idx_r == 4'd8 || idx_r == 4'd11) begin
            di_r    <= (idx_r == 4'd5) ? 2'd0 : ((idx_r == 4'd8) ? 2'd1 : 2'd2);
            state_r <= ST_DSTART;
          end else begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_WSTART;
          end
        end
        ST_DET: begin
          if (stat.det_zero) begin
            state_r <= ST_SING;
          end else begin
            idx_r   <= 4'd3;
            state_r <= ST_WSTART;
          end
        end
        ST_SING:   state_r <= ST_OUT;
        ST_DSTART: state_r <= ST_DWAIT;
        ST_DWAIT: if (stat.div_done) begin
          if (di_r == 2'd2) begin
            state_r <= ST_OUT;
          end else begin
            idx_r   <= idx_r + 4'd1;
            state_r <= ST_WSTART;
          end
        end
        ST_OUT: if (out_tready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.idx = idx_r;
    unique case (state_r)
      ST_SQ:     cmd.op = albf_pkg::OP_SQ;
      ST_C:      cmd.op = albf_pkg::OP_C;
      ST_B:      cmd.op = albf_pkg::OP_B;
      ST_A:      cmd.op = albf_pkg::OP_A;
      ST_SIN:    cmd.op = albf_pkg::OP_SIN;
      ST_BASIS:  cmd.op = albf_pkg::OP_BASIS;
      ST_QUAD:   cmd.op = albf_pkg::OP_QUAD;
      ST_ACC:    cmd.op = albf_pkg::OP_ACC;
      ST_LOAD:   cmd.op = albf_pkg::OP_LOAD;
      ST_SHIFT:  cmd.op = albf_pkg::OP_SHIFT;
      ST_COF:    cmd.op = albf_pkg::OP_COF;
      ST_WSTART: cmd.op = albf_pkg::OP_WSTART;
      ST_WWAIT:  cmd.op = albf_pkg::OP_WWAIT;
      ST_DET:    cmd.op = albf_pkg::OP_DET;
      ST_SING:   cmd.op = albf_pkg::OP_SING;
      ST_DSTART: begin cmd.op = albf_pkg::OP_DSTART; cmd.idx = {2'd0, di_r}; end
      ST_DWAIT:  begin cmd.op = albf_pkg::OP_DWAIT;  cmd.idx = {2'd0, di_r}; end
      default:   cmd.op = albf_pkg::OP_NOP;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);

endmodule

FILE: rtl/angular_basis_ls_fit_top.sv
// ----------------------------------------------------------------------------
// angular_basis_ls_fit_top
// Least-squares fit of three coefficients over samples of angle and value.
// ----------------------------------------------------------------------------
// Each input word carries a phase angle and a signed sample; tlast marks the
// final sample of a set. The cfg channel sets the basis mode (bit 0) and is
// always ready. Each sample is processed on the one shared 33x33 multiplier,
// which evaluates the sine polynomial twice, forms the basis terms in
// quadratic mode and accumulates nine products. A sample with tlast then
// starts the solve: a scaling shift, the cofactors, twelve wide products on
// a bit-serial multiplier and three quotients on a serial divider; a zero
// determinant ends it early with a singular, all-zero result. The result
// word holds until taken; while out_tvalid waits on out_tready no new
// sample is taken.
// Reset clears the accumulators, the sample count and the mode.
// ----------------------------------------------------------------------------
module angular_basis_ls_fit_top #(
  parameter int MAX_SAMPLES = 1024,
  parameter int ANGLE_BITS  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_tvalid,
  output logic                                           in_tready,
  // angle, sample_value
  input  logic [((ANGLE_BITS+SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                           in_tlast,
  output logic                                           out_tvalid,
  input  logic                                           out_tready,
  // coef_first, coef_second, coef_third
  output logic [95:0]                                    out_tdata,
  // singular
  output logic                                           out_tuser,
  input  logic                                           cfg_tvalid,
  output logic                                           cfg_tready,
  // basis_mode
  input  logic [7:0]                                     cfg_tdata
);

  albf_pkg::cmd_t  cmd;
  albf_pkg::stat_t stat;
  logic            in_accept;
  logic [31:0]     c0, c1, c2;

  assign in_accept  = in_tvalid & in_tready;
  assign cfg_tready = 1'b1;

  albf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  albf_dpath #(
    .ANGLE_BITS  (ANGLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (in_accept),
    .angle        (in_tdata[ANGLE_BITS-1:0]),
    .sample_value (in_tdata[ANGLE_BITS+SAMPLE_BITS-1:ANGLE_BITS]),
    .last         (in_tlast),
    .cfg_we       (cfg_tvalid),
    .cfg_mode     (cfg_tdata[0]),
    .cmd          (cmd),
    .stat         (stat),
    .coef_first   (c0),
    .coef_second  (c1),
    .coef_third   (c2),
    .singular     (out_tuser)
  );

  assign out_tdata = {c2, c1, c0};

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the angular basis least-squares fit.
// ----------------------------------------------------------------------------
// Sample words are streamed in sets that end with tlast. Both basis modes are
// used. A local fixed-point model accumulates the normal matrix and solves it.
// Each result word is compared with the oldest predicted fit. Directed sets
// cover the field extremes, the singular matrix and a mode change within a
// set. Random sets follow, with random idle gaps on the input side and random
// stalls on the output side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          MAX_SAMPLES = 1024;
  localparam int          SETTLE      = 40;
  localparam logic        MODE_QUAD   = 1'b0;
  localparam logic        MODE_HARM   = 1'b1;

  typedef struct {
    logic signed [31:0] coef [3];
    logic               singular;
  } fit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        cfg_tvalid = 1'b0;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata = '0;

  fit_t               fit_q[$];
  logic signed [47:0] nsum [6];
  logic signed [47:0] rsum [3];
  int                 nsamp;
  logic               mode;
  int                 errors;
  bit                 quiet;

  angular_basis_ls_fit_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic longint quarter_sine(longint unsigned t);
    longint unsigned z2, w;
    z2 = (t * t) >> 14;
    w = (64'd76016977 * z2) >> 14;
    w = ((64'd688904866 - w) * z2) >> 14;
    w = 64'd1686629713 - w;
    return longint'((w * t + (64'd1 << 28)) >> 29);
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic accumulate(logic [15:0] angle, logic signed [15:0] value);
    longint c, s, t, b [3], v;
    logic [1:0] quad;
    quad = angle[15:14];
    t = angle[13:0];
    v = value;
    case (quad)
      2'd0: begin s = quarter_sine(t); c = quarter_sine(16384 - t); end
      2'd1: begin s = quarter_sine(16384 - t); c = -quarter_sine(t); end
      2'd2: begin s = -quarter_sine(t); c = -quarter_sine(16384 - t); end
      default: begin s = -quarter_sine(16384 - t); c = quarter_sine(t); end
    endcase
    if (mode == MODE_QUAD) begin
      b[0] = (c * c + (1 << 14)) >>> 15;
      b[1] = (s * s + (1 << 14)) >>> 15;
      b[2] = (c * s + (1 << 13)) >>> 14;
    end else begin
      b[0] = c;
      b[1] = s;
      b[2] = 32768;
    end
    if (nsamp < MAX_SAMPLES) begin
      nsum[0] += 48'(b[0] * b[0]);
      nsum[1] += 48'(b[0] * b[1]);
      nsum[2] += 48'(b[0] * b[2]);
      nsum[3] += 48'(b[1] * b[1]);
      nsum[4] += 48'(b[1] * b[2]);
      nsum[5] += 48'(b[2] * b[2]);
      for (int i = 0; i < 3; i++) rsum[i] += 48'(b[i] * v);
      nsamp++;
    end
  endtask

  function automatic fit_t solve_fit();
    fit_t               f;
    longint             e [6], m [3][3], r [3], a [3][3];
    logic signed [127:0] det, num, q;
    int                 k;
    bit                 fits;
    k = 0;
    fits = 0;
    while (!fits && k < 62) begin
      fits = 1;
      for (int i = 0; i < 6; i++) begin
        e[i] = longint'(nsum[i]) >>> k;
        if (e[i] > (64'sd1 << 30) || e[i] < -(64'sd1 << 30)) fits = 0;
      end
      if (!fits) k++;
    end
    m[0][0] = e[0]; m[0][1] = e[1]; m[0][2] = e[2];
    m[1][0] = e[1]; m[1][1] = e[3]; m[1][2] = e[4];
    m[2][0] = e[2]; m[2][1] = e[4]; m[2][2] = e[5];
    for (int i = 0; i < 3; i++) r[i] = longint'(rsum[i]) >>> k;
    a[0][0] = m[1][1] * m[2][2] - m[1][2] * m[2][1];
    a[0][1] = m[0][2] * m[2][1] - m[0][1] * m[2][2];
    a[0][2] = m[0][1] * m[1][2] - m[0][2] * m[1][1];
    a[1][0] = m[1][2] * m[2][0] - m[1][0] * m[2][2];
    a[1][1] = m[0][0] * m[2][2] - m[0][2] * m[2][0];
    a[1][2] = m[0][2] * m[1][0] - m[0][0] * m[1][2];
    a[2][0] = m[1][0] * m[2][1] - m[1][1] * m[2][0];
    a[2][1] = m[0][1] * m[2][0] - m[0][0] * m[2][1];
    a[2][2] = m[0][0] * m[1][1] - m[0][1] * m[1][0];
    det = 128'(m[0][0]) * 128'(a[0][0]) + 128'(m[0][1]) * 128'(a[1][0])
        + 128'(m[0][2]) * 128'(a[2][0]);
    f.singular = (det == 0);
    for (int i = 0; i < 3; i++) begin
      f.coef[i] = '0;
      if (!f.singular) begin
        num = 128'(a[i][0]) * 128'(r[0]) + 128'(a[i][1]) * 128'(r[1])
            + 128'(a[i][2]) * 128'(r[2]);
        num = num <<< 16;
        q = num / det;
        if (q > 128'sh7fffffff) f.coef[i] = 32'h7fffffff;
        else if (q < -128'sh80000000) f.coef[i] = 32'h80000000;
        else f.coef[i] = q[31:0];
      end
    end
    return f;
  endfunction

  task automatic clear_sums();
    for (int i = 0; i < 6; i++) nsum[i] = '0;
    for (int i = 0; i < 3; i++) rsum[i] = '0;
    nsamp = 0;
  endtask

  task automatic send_sample(logic [15:0] angle, logic signed [15:0] value, logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {value, angle};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    accumulate(angle, value);
    if (last) begin
      fit_q.push_back(solve_fit());
      clear_sums();
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (fit_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    wait_idle();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {7'd0, m};
    do @(posedge clk); while (!cfg_tready);
    mode = m;
    cfg_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n) out_tready <= quiet ? 1'b1 : (gap_len() == 0);
  end

  always @(posedge clk) begin
    fit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (fit_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", out_tdata);
      end else begin
        want = fit_q.pop_front();
        if (out_tdata[31:0] !== want.coef[0] || out_tdata[63:32] !== want.coef[1] ||
            out_tdata[95:64] !== want.coef[2] || out_tuser !== want.singular) begin
          errors++;
          if (errors <= 10)
            $display("fit mismatch: want %h %h %h s%b got %h %h %h s%b",
                     want.coef[0], want.coef[1], want.coef[2], want.singular,
                     out_tdata[31:0], out_tdata[63:32], out_tdata[95:64], out_tuser);
        end
      end
    end
  end

  task automatic test_extremes();
    for (int md = 0; md < 2; md++) begin
      write_mode(md[0]);
      send_sample(16'd0, 16'sh7fff, 1'b0);
      send_sample(16'd16384, -16'sh8000, 1'b0);
      send_sample(16'd32768, 16'sd1, 1'b0);
      send_sample(16'd49152, -16'sd1, 1'b0);
      send_sample(16'hffff, 16'sd0, 1'b0);
      send_sample(16'd8192, 16'sh5555, 1'b1);
    end
  endtask

  task automatic test_singular();
    write_mode(MODE_QUAD);
    send_sample(16'h2aaa, 16'sd1000, 1'b1);
    send_sample(16'd0, 16'sd5, 1'b0);
    send_sample(16'd0, 16'sd7, 1'b1);
    write_mode(MODE_HARM);
    send_sample(16'd12345, -16'sd300, 1'b1);
  endtask

  task automatic test_mode_change();
    write_mode(MODE_QUAD);
    send_sample(16'd1000, 16'sd200, 1'b0);
    send_sample(16'd20000, -16'sd900, 1'b0);
    write_mode(MODE_HARM);
    send_sample(16'd40000, 16'sd4000, 1'b0);
    send_sample(16'd60000, 16'sd123, 1'b1);
  endtask

  task automatic test_random();
    int sent, len;
    sent = 0;
    while (sent < 650) begin
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom));
      else if ($urandom_range(0, 7) == 0) wait_idle();
      quiet = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0: send_sample(16'($urandom), 16'sh7fff, i == len - 1);
          1: send_sample(16'($urandom), -16'sh8000, i == len - 1);
          default: send_sample(16'($urandom), 16'($urandom), i == len - 1);
        endcase
        sent++;
      end
    end
    quiet = 0;
  endtask

  initial begin
    errors = 0;
    quiet = 0;
    mode = MODE_QUAD;
    clear_sums();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_singular();
    test_mode_change();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/albf_pkg.sv
rtl/albf_smul.sv
rtl/albf_div.sv
rtl/albf_dpath.sv
rtl/albf_ctrl.sv
rtl/angular_basis_ls_fit_top.sv
tb/tb_top.sv
